### hw/rtl/erd_pkg.sv
package erd_pkg;

  localparam int HoldDepth = 4;
  localparam int MaxRes    = 6;
  localparam int ResCntW   = 3;
  localparam int LineW     = 16;
  localparam int BodyW     = 21;
  localparam int CfgIdxW   = 2;

  localparam logic [1:0] KIND_BODY = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_MAX_LINE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_BODY  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LINES = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [BodyW-1:0] BODY_SAT = 21'h1FFFFF;

  localparam logic [LineW-1:0] RST_MAX_LINE  = 16'd4096;
  localparam logic [BodyW-1:0] RST_MAX_BODY  = 21'd65536;
  localparam logic [LineW-1:0] RST_MAX_LINES = 16'd2048;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_fail;
  } erd_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] body_byte;
    logic       last;
  } erd_out_t;

  typedef struct packed {
    logic [LineW-1:0] line_cap;
    logic [BodyW-1:0] body_cap;
    logic [LineW-1:0] lines_cap;
  } erd_cfg_t;

  // All results caused by one received byte.
  typedef struct packed {
    logic [ResCntW-1:0]           cnt;
    logic [MaxRes-1:0][1:0]       kind;
    logic [MaxRes-1:0][7:0]       data;
  } erd_burst_t;

  function automatic logic [7:0] end_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h45;
      2'd1:    c = 8'h4E;
      2'd2:    c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bad_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h42;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h64;
      4'd3:    c = 8'h20;
      4'd4:    c = 8'h63;
      4'd5:    c = 8'h6F;
      4'd6:    c = 8'h6D;
      4'd7:    c = 8'h6D;
      4'd8:    c = 8'h61;
      4'd9:    c = 8'h6E;
      4'd10:   c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/erd_engine.sv
module erd_engine
  import erd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  erd_in_t    item,
  input  erd_cfg_t   cfg,
  output erd_burst_t burst
);

  logic [7:0]       hb_r [HoldDepth];
  logic [2:0]       hc_r, hc_nxt;
  logic             em_r, em_nxt;
  logic [LineW-1:0] lp_r, lp_nxt;
  logic             ls_r, ls_nxt;
  logic             ns_r, ns_nxt;
  logic             sd_r, sd_nxt;
  logic [BodyW-1:0] bl_r, bl_nxt;
  logic [LineW-1:0] lc_r, lc_nxt;
  logic             ep_r, ep_nxt;
  logic             bp_r, bp_nxt;

  logic [7:0]         rx;
  logic               is_lf, is_nul;
  logic [2:0]         hc_m1, n_lf, hc1;
  logic               crtail, end_line, em1;
  logic               hold_cr, hold_end, hold;
  logic [2:0]         flush_n;
  logic               emit_b, force_sep, sep;
  logic [ResCntW-1:0] cnt_body;
  logic [7:0]         seq [MaxRes];
  logic               ep_upd, bp_upd;
  logic [BodyW:0]     bl_sum;
  logic [BodyW-1:0]   bl_new;
  logic [BodyW+1:0]   ovf_sum;
  logic               body_ovf;
  logic [LineW:0]     lp_inc, lc_inc;
  logic               line_ovf, lines_ovf, pre_fail, err_reply;
  logic               wr_hold;

  assign rx     = item.rx_byte;
  assign is_lf  = (rx == CH_LF);
  assign is_nul = (rx == CH_NUL);

  // A CR is only ever held as the last byte of the hold buffer.
  assign hc_m1    = hc_r - 3'd1;
  assign crtail   = (hc_r != 3'd0) && (hb_r[hc_m1[1:0]] == CH_CR);
  assign n_lf     = crtail ? hc_m1 : hc_r;
  assign end_line = em_r && (n_lf == 3'd3);
  assign hc1      = crtail ? 3'd0 : hc_r;
  assign em1      = !crtail && em_r;
  assign hold_cr  = (rx == CH_CR) && (hc1 < 3'(HoldDepth));
  assign hold_end = em1 && (hc1 < 3'd3) && (rx == end_char(hc1[1:0]));
  assign hold     = hold_cr || hold_end;

  // What the byte emits as content: a number of held bytes, then maybe itself.
  always_comb begin
    flush_n   = 3'd0;
    emit_b    = 1'b0;
    force_sep = 1'b0;
    if (is_lf) begin
      flush_n   = n_lf;
      force_sep = 1'b1;
    end else if (ns_r) begin
      flush_n = 3'd0;
    end else if (is_nul) begin
      flush_n = (em_r && hc_r == 3'd3) ? 3'd0 : hc_r;
    end else begin
      flush_n = (crtail || !hold) ? hc_r : 3'd0;
      emit_b  = !hold;
    end
  end

  assign sep      = sd_r && !ls_r && (force_sep || flush_n != 3'd0 || emit_b);
  assign cnt_body = {2'b00, sep} + flush_n + {2'b00, emit_b};

  // Body byte sequence and the running ERROR / Bad command prefix checks.
  always_comb begin
    logic [2:0] k;
    logic [4:0] pos;
    ep_upd = ep_r;
    bp_upd = bp_r;
    for (int j = 0; j < MaxRes; j++) begin
      k = 3'(j) - {2'b00, sep};
      if (sep && j == 0) begin
        seq[j] = CH_LF;
      end else if (k < flush_n) begin
        seq[j] = hb_r[k[1:0]];
      end else begin
        seq[j] = rx;
      end
      pos = 5'(bl_r[3:0]) + 5'(j);
      if ((3'(j) < cnt_body) && (bl_r[BodyW-1:4] == '0)) begin
        if ((pos < 5'd5) && (seq[j] != err_char(pos[2:0]))) begin
          ep_upd = 1'b0;
        end
        if ((pos < 5'd11) && (seq[j] != bad_char(pos[3:0]))) begin
          bp_upd = 1'b0;
        end
      end
    end
  end

  assign bl_sum    = {1'b0, bl_r} + (BodyW+1)'(cnt_body);
  assign bl_new    = (bl_sum > {1'b0, BODY_SAT}) ? BODY_SAT : bl_sum[BodyW-1:0];
  assign ovf_sum   = {2'b00, bl_r} + (BodyW+2)'(cnt_body) + (BodyW+2)'(1);
  assign body_ovf  = ovf_sum > {2'b00, cfg.body_cap};
  assign lp_inc    = {1'b0, lp_r} + (LineW+1)'(1);
  assign lc_inc    = {1'b0, lc_r} + (LineW+1)'(1);
  assign line_ovf  = lp_inc >= {1'b0, cfg.line_cap};
  assign lines_ovf = lc_inc >= {1'b0, cfg.lines_cap};
  assign pre_fail  = item.link_fail || (lc_r >= cfg.lines_cap) ||
                     (lp_r >= cfg.line_cap);
  assign err_reply = (ep_r && bl_r >= 21'd5) || (bp_r && bl_r >= 21'd11);

  always_comb begin
    hc_nxt  = hc_r;
    em_nxt  = em_r;
    lp_nxt  = lp_r;
    ls_nxt  = ls_r;
    ns_nxt  = ns_r;
    sd_nxt  = sd_r;
    bl_nxt  = bl_r;
    lc_nxt  = lc_r;
    ep_nxt  = ep_r;
    bp_nxt  = bp_r;
    wr_hold = 1'b0;
    burst   = '0;
    if (pre_fail || (is_lf && !end_line && (body_ovf || lines_ovf)) ||
        (!is_lf && line_ovf)) begin
      burst.cnt     = 3'd1;
      burst.kind[0] = KIND_FAIL;
    end else if (is_lf && end_line) begin
      burst.cnt     = 3'd1;
      burst.kind[0] = err_reply ? KIND_ERR : KIND_OK;
    end else begin
      burst.cnt = cnt_body;
      for (int j = 0; j < MaxRes; j++) begin
        burst.kind[j] = KIND_BODY;
        burst.data[j] = (3'(j) < cnt_body) ? seq[j] : 8'h00;
      end
      bl_nxt = bl_new;
      ep_nxt = ep_upd;
      bp_nxt = bp_upd;
      if (is_lf) begin
        sd_nxt = (bl_new != '0);
        lc_nxt = lc_inc[LineW-1:0];
        hc_nxt = 3'd0;
        em_nxt = 1'b1;
        lp_nxt = '0;
        ls_nxt = 1'b0;
        ns_nxt = 1'b0;
      end else begin
        lp_nxt = lp_inc[LineW-1:0];
        ls_nxt = ls_r || (flush_n != 3'd0) || emit_b;
        if (ns_r) begin
          ls_nxt = ls_r;
        end else if (is_nul) begin
          ns_nxt = 1'b1;
          if (!(em_r && hc_r == 3'd3)) begin
            hc_nxt = 3'd0;
            em_nxt = 1'b0;
          end
        end else if (hold) begin
          wr_hold = 1'b1;
          hc_nxt  = hc1 + 3'd1;
          em_nxt  = em1;
        end else begin
          hc_nxt = 3'd0;
          em_nxt = 1'b0;
        end
      end
    end
    // Failure and close both rearm for the next reply.
    if (burst.cnt == 3'd1 && burst.kind[0] != KIND_BODY) begin
      hc_nxt = 3'd0;
      em_nxt = 1'b1;
      lp_nxt = '0;
      ls_nxt = 1'b0;
      ns_nxt = 1'b0;
      sd_nxt = 1'b0;
      bl_nxt = '0;
      lc_nxt = '0;
      ep_nxt = 1'b1;
      bp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= 3'd0;
      em_r <= 1'b1;
      lp_r <= '0;
      ls_r <= 1'b0;
      ns_r <= 1'b0;
      sd_r <= 1'b0;
      bl_r <= '0;
      lc_r <= '0;
      ep_r <= 1'b1;
      bp_r <= 1'b1;
    end else if (go) begin
      hc_r <= hc_nxt;
      em_r <= em_nxt;
      lp_r <= lp_nxt;
      ls_r <= ls_nxt;
      ns_r <= ns_nxt;
      sd_r <= sd_nxt;
      bl_r <= bl_nxt;
      lc_r <= lc_nxt;
      ep_r <= ep_nxt;
      bp_r <= bp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && wr_hold) begin
      hb_r[hc1[1:0]] <= rx;
    end
  end

  a_hold_depth : assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= 3'(HoldDepth))
    else $error("hold count beyond hold depth");

  a_term_single : assert property (@(posedge clk) disable iff (!rst_n)
    (burst.cnt != 3'd1 && burst.cnt != 3'd0) |-> burst.kind[0] == KIND_BODY)
    else $error("terminal result shares a burst with other results");

  a_rearm : assert property (@(posedge clk) disable iff (!rst_n)
    (go && burst.cnt == 3'd1 && burst.kind[0] != KIND_BODY)
      |=> (bl_r == '0 && lc_r == '0 && hc_r == 3'd0))
    else $error("reply state not rearmed after close or failure");

endmodule

### hw/rtl/erd_outq.sv
module erd_outq
  import erd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  erd_burst_t burst,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output erd_out_t   out_data
);

  logic [1:0]         kind_r [MaxRes];
  logic [7:0]         data_r [MaxRes];
  logic [ResCntW-1:0] cnt_r, idx_r;
  logic [ResCntW-1:0] idx_inc, rd;
  logic               out_acc;

  assign idx_inc   = idx_r + 3'd1;
  assign out_valid = (idx_r != cnt_r);
  assign out_acc   = out_valid && !out_stall;
  // Free when empty, or when the final beat of the burst leaves this cycle.
  assign ready     = !out_valid || (out_acc && idx_inc == cnt_r);
  assign rd        = (idx_r < 3'(MaxRes)) ? idx_r : 3'd0;

  assign out_data.out_kind  = kind_r[rd];
  assign out_data.body_byte = data_r[rd];
  assign out_data.last      = (idx_inc == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
      idx_r <= '0;
    end else if (out_acc) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < MaxRes; j++) begin
        kind_r[j] <= burst.kind[j];
        data_r[j] <= burst.data[j];
      end
    end
  end

  a_idx_bound : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cnt_r)
    else $error("read index passed the burst length");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MaxRes))
    else $error("burst longer than the result buffer");

  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    (load && burst.cnt != '0) |=> (out_valid && idx_r == '0))
    else $error("loaded burst not presented");

endmodule

### hw/rtl/end_terminated_reply_deframer_core.sv
// Channel | Ports                              | Direction | Beat
// input   | in_valid, in_stall, in_data        | in        | one received byte or link failure
// result  | out_valid, out_stall, out_data     | out       | one body byte or one reply status
// config  | cfg_we, cfg_index, cfg_wdata       | in        | one register write
// A byte is decoded into up to six results while it sits in the input register;
// the results are loaded into the result buffer and leave one per cycle unless stalled.
// Bytes that give at most one result flow at one per cycle while the output is not stalled;
// a byte that flushes held bytes occupies the result buffer until its last result leaves.
// Reset is synchronous and active low; it restores the register defaults and rearms.
// Output stall holds the result buffer, which in turn stalls the input register.
module end_terminated_reply_deframer_core
  import erd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  erd_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output erd_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [BodyW-1:0]   cfg_wdata
);

  erd_cfg_t   cfg_r;
  erd_in_t    in_r;
  logic       in_valid_r;
  logic       q_ready, go, in_acc;
  erd_burst_t burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_cap  <= RST_MAX_LINE;
      cfg_r.body_cap  <= RST_MAX_BODY;
      cfg_r.lines_cap <= RST_MAX_LINES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LINE:  cfg_r.line_cap  <= cfg_wdata[LineW-1:0];
        REG_MAX_BODY:  cfg_r.body_cap  <= cfg_wdata;
        REG_MAX_LINES: cfg_r.lines_cap <= cfg_wdata[LineW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign go       = in_valid_r && q_ready;
  assign in_stall = in_valid_r && !q_ready;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  erd_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_r),
    .cfg   (cfg_r),
    .burst (burst)
  );

  erd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .burst     (burst),
    .ready     (q_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/end_terminated_reply_deframer_core_test.sv
module end_terminated_reply_deframer_core_test;
  import erd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int LongHold    = 80;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 40;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  erd_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  erd_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [BodyW-1:0]   cfg_wdata = '0;

  end_terminated_reply_deframer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copies and deframer state.
  logic [LineW-1:0] lim_line  = RST_MAX_LINE;
  logic [BodyW-1:0] lim_body  = RST_MAX_BODY;
  logic [LineW-1:0] lim_lines = RST_MAX_LINES;

  logic [7:0]  held [HoldDepth];
  int unsigned held_n;
  int unsigned raw_pos;
  int unsigned content_len;
  int unsigned body_count;
  int unsigned lines_done;
  bit          end_pref;
  bit          nul_hit;
  bit          need_sep;
  bit          err_pref;
  bit          bad_pref;

  string end_text = "END";
  string err_text = "ERROR";
  string bad_text = "Bad command";

  erd_out_t step_results[$];
  erd_out_t expected_results[$];
  erd_in_t  pending_bytes[$];

  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  bit want_long_hold = 1'b0;
  int hold_cycles    = 0;

  function automatic void add_result(logic [1:0] kind, logic [7:0] data);
    erd_out_t r;
    if (step_results.size() < MaxRes) begin
      r.out_kind  = kind;
      r.body_byte = data;
      r.last      = 1'b0;
      step_results.push_back(r);
    end
  endfunction

  function automatic void start_line();
    foreach (held[i]) held[i] = CH_NUL;
    held_n      = 0;
    end_pref    = 1'b1;
    raw_pos     = 0;
    content_len = 0;
    nul_hit     = 1'b0;
  endfunction

  function automatic void rearm_reply();
    start_line();
    need_sep   = 1'b0;
    body_count = 0;
    lines_done = 0;
    err_pref   = 1'b1;
    bad_pref   = 1'b1;
  endfunction

  function automatic void put_body(logic [7:0] b);
    if (body_count < 5 && b != err_text[body_count]) err_pref = 1'b0;
    if (body_count < 11 && b != bad_text[body_count]) bad_pref = 1'b0;
    if (body_count < BODY_SAT) body_count++;
    add_result(KIND_BODY, b);
  endfunction

  function automatic void put_content(logic [7:0] b);
    if (need_sep && content_len == 0) put_body(CH_LF);
    put_body(b);
    if (content_len < 16'hFFFF) content_len++;
  endfunction

  function automatic void release_held();
    for (int i = 0; i < held_n && i < HoldDepth; i++) put_content(held[i]);
    held_n   = 0;
    end_pref = 1'b0;
  endfunction

  // A failing byte reports only the failure, never the bytes it was holding.
  function automatic void fail_reply();
    step_results.delete();
    add_result(KIND_FAIL, CH_NUL);
    rearm_reply();
  endfunction

  function automatic void line_end();
    int unsigned n;
    int unsigned pend;
    bit          is_err;
    n = held_n;
    if (n > 0 && n <= HoldDepth && held[n-1] == CH_CR) n--;
    if (end_pref && n == 3) begin
      is_err = (err_pref && body_count >= 5) || (bad_pref && body_count >= 11);
      add_result(is_err ? KIND_ERR : KIND_OK, CH_NUL);
      rearm_reply();
    end else begin
      pend = n + ((need_sep && content_len == 0) ? 1 : 0);
      if (body_count + pend + 1 > lim_body || lines_done + 1 >= lim_lines) begin
        fail_reply();
      end else begin
        for (int i = 0; i < n; i++) put_content(held[i]);
        // An empty line in the middle of the body still needs its separator.
        if (need_sep && content_len == 0) put_body(CH_LF);
        need_sep = body_count > 0;
        lines_done++;
        start_line();
      end
    end
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    raw_pos++;
    if (raw_pos >= lim_line) begin
      fail_reply();
    end else if (!nul_hit) begin
      if (b == CH_NUL) begin
        nul_hit = 1'b1;
        if (!(end_pref && held_n == 3)) release_held();
      end else begin
        // A held CR that is not followed by LF turns into content.
        if (held_n > 0 && held_n <= HoldDepth && held[held_n-1] == CH_CR) release_held();
        if (b == CH_CR && held_n < HoldDepth) begin
          held[held_n] = b;
          held_n++;
        end else if (end_pref && held_n < 3 && b == end_text[held_n]) begin
          held[held_n] = b;
          held_n++;
        end else begin
          release_held();
          put_content(b);
        end
      end
    end
  endfunction

  function automatic void deframe_byte(erd_in_t beat);
    step_results.delete();
    if (beat.link_fail || lines_done >= lim_lines || raw_pos >= lim_line) fail_reply();
    else if (beat.rx_byte == CH_LF) line_end();
    else plain_byte(beat.rx_byte);
    foreach (step_results[i]) begin
      erd_out_t r;
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    erd_in_t t;
    t.rx_byte   = b;
    t.link_fail = 1'b0;
    pending_bytes.push_back(t);
    bytes_queued++;
  endfunction

  function automatic void push_link_fail();
    erd_in_t t;
    t.rx_byte   = 8'($urandom_range(255));
    t.link_fail = 1'b1;
    pending_bytes.push_back(t);
    bytes_queued++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_line_end();
    if ($urandom_range(3) == 0) push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  function automatic logic [7:0] rand_content();
    logic [7:0] c;
    case ($urandom_range(15))
      0:       c = CH_CR;
      1:       c = CH_NUL;
      2:       c = "E";
      3:       c = "N";
      4:       c = "D";
      5, 6:    c = 8'($urandom_range(255));
      default: c = 8'($urandom_range(126, 32));
    endcase
    return c;
  endfunction

  // A well-formed reply: optional leading empty lines, a few body lines, END.
  function automatic void gen_reply();
    int lines;
    int len;
    repeat ($urandom_range(2)) push_line_end();
    lines = $urandom_range(3);
    for (int l = 0; l < lines; l++) begin
      if (l == 0) begin
        case ($urandom_range(5))
          0:       push_text("ERROR");
          1:       push_text("Bad command");
          2:       push_text("ERR");
          3:       push_text("Bad c");
          default: ;
        endcase
      end
      len = $urandom_range(6);
      repeat (len) push_byte(rand_content());
      push_line_end();
    end
    push_text("END");
    push_line_end();
  endfunction

  // Lines that look like the terminator but are not, or a reply cut short.
  function automatic void gen_broken();
    case ($urandom_range(6))
      0: push_text("EN");
      1: push_text("ENDD");
      2: begin push_text("END"); push_byte(CH_CR); push_byte(CH_CR); end
      3: begin push_text("E"); push_byte(CH_NUL); push_text("ND"); end
      4: begin push_text("END"); push_byte(CH_NUL); push_text("x"); end
      5: begin push_byte(CH_CR); push_text("END"); end
      default: begin
        repeat ($urandom_range(1, 5)) push_byte(rand_content());
        push_link_fail();
        return;
      end
    endcase
    push_byte(CH_LF);
  endfunction

  function automatic void gen_chunk();
    int r;
    r = $urandom_range(99);
    if (r < 65) gen_reply();
    else if (r < 75) push_link_fail();
    else if (r < 88) gen_broken();
    else repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
  endfunction

  function automatic void fill_random(int n);
    int target;
    target = pending_bytes.size() + n;
    while (pending_bytes.size() < target) gen_chunk();
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [BodyW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_LINE:  lim_line  = value[LineW-1:0];
      REG_MAX_BODY:  lim_body  = value;
      REG_MAX_LINES: lim_lines = value[LineW-1:0];
      default:       ;
    endcase
  endtask

  // Held bytes give no result, so the pipeline may still be busy when the
  // queue of expected results runs empty; the extra cycles cover that.
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Sender: presents a new beat once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to fill the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (want_long_hold && hold_cycles < LongHold) begin
      hold_cycles <= hold_cycles + 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    erd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < MaxReports)
          $display("%0t: result with none expected, expected none, got %h", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.out_kind !== want.out_kind) begin
          mismatch_count++;
          if (mismatch_count < MaxReports)
            $display("%0t: out_kind expected %0d got %0d", $time, want.out_kind,
                     out_data.out_kind);
        end
        if (out_data.body_byte !== want.body_byte) begin
          mismatch_count++;
          if (mismatch_count < MaxReports)
            $display("%0t: body_byte expected %h got %h", $time, want.body_byte,
                     out_data.body_byte);
        end
        if (out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count < MaxReports)
            $display("%0t: last expected %0d got %0d", $time, want.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end_terminated_reply_deframer_core verification failed");
      $finish;
    end
  end

  initial begin
    rearm_reply();
    send_idle_pct = 19;
    recv_idle_pct = 56;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    push_link_fail();
    push_byte(CH_LF);
    push_text("END");
    push_byte(CH_LF);
    push_text("ERROR");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_text("END");
    push_byte(CH_LF);
    push_byte(8'hFF);
    push_byte(CH_CR);
    push_byte(CH_NUL);
    push_text("q");
    push_byte(CH_LF);
    push_text("EN");
    push_link_fail();
    wait_drained();

    write_reg(REG_MAX_LINE, 21'd65535);
    write_reg(REG_MAX_BODY, 21'h100000);
    write_reg(REG_MAX_LINES, 21'd65535);
    fill_random(45);
    // Leave a reply open so that the lowered limits below hit it.
    push_text("abcd");
    push_byte(CH_LF);
    push_text("xyz");
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 19;
    write_reg(REG_MAX_LINE, 21'd2);
    write_reg(REG_MAX_BODY, 21'd1);
    write_reg(REG_MAX_LINES, 21'd1);
    fill_random(10);
    wait_drained();

    write_reg(REG_MAX_LINE, BodyW'($urandom_range(24, 6)));
    write_reg(REG_MAX_BODY, BodyW'($urandom_range(60, 8)));
    write_reg(REG_MAX_LINES, BodyW'($urandom_range(6, 2)));
    fill_random(35);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_MAX_LINE, BodyW'(RST_MAX_LINE));
    write_reg(REG_MAX_BODY, RST_MAX_BODY);
    write_reg(REG_MAX_LINES, BodyW'(RST_MAX_LINES));
    fill_random(40);
    want_long_hold = 1'b1;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("end_terminated_reply_deframer_core verification clean");
    end else begin
      $display("end_terminated_reply_deframer_core verification failed");
    end
    $finish;
  end

endmodule
